[rtl/smc_pkg.sv]
// shared types, opcodes and constants of the stack machine core
// used by every module of the block but smc_ram; depends on nothing
package smc_pkg;

  localparam int unsigned MemWordsDef = 4096;
  localparam int unsigned WordW       = 32;
  localparam int unsigned AddrInW     = 12;
  localparam int unsigned ErrW        = 7;
  localparam int unsigned BodyW       = 30;
  localparam int unsigned IdxW        = 3;

  // request kinds
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // instruction headers
  localparam logic [1:0] HDR_PRIM = 2'd1;
  localparam logic [1:0] HDR_SKIP = 2'd3;

  // error codes
  localparam logic [ErrW-1:0] ERR_DIV0  = 7'd64;
  localparam logic [ErrW-1:0] ERR_UNDEF = 7'd66;

  // primitives
  localparam logic [BodyW-1:0] OP_HALT    = 30'd0;
  localparam logic [BodyW-1:0] OP_DUPL    = 30'd27;
  localparam logic [BodyW-1:0] OP_T2A     = 30'd28;
  localparam logic [BodyW-1:0] OP_A2T     = 30'd29;
  localparam logic [BodyW-1:0] OP_PUSH    = 30'd30;
  localparam logic [BodyW-1:0] OP_POP     = 30'd31;
  localparam logic [BodyW-1:0] OP_ADD     = 30'd32;
  localparam logic [BodyW-1:0] OP_SUB     = 30'd33;
  localparam logic [BodyW-1:0] OP_MUL     = 30'd34;
  localparam logic [BodyW-1:0] OP_DIV     = 30'd35;
  localparam logic [BodyW-1:0] OP_MOD     = 30'd36;
  localparam logic [BodyW-1:0] OP_AND     = 30'd37;
  localparam logic [BodyW-1:0] OP_OR      = 30'd38;
  localparam logic [BodyW-1:0] OP_XOR     = 30'd39;
  localparam logic [BodyW-1:0] OP_NOT     = 30'd40;
  localparam logic [BodyW-1:0] OP_SHL     = 30'd41;
  localparam logic [BodyW-1:0] OP_SHR     = 30'd42;
  localparam logic [BodyW-1:0] OP_EQ      = 30'd43;
  localparam logic [BodyW-1:0] OP_LT      = 30'd44;
  localparam logic [BodyW-1:0] OP_GT      = 30'd45;
  localparam logic [BodyW-1:0] OP_TRACE   = 30'd128;
  localparam logic [BodyW-1:0] OP_GOTO    = 30'd129;
  localparam logic [BodyW-1:0] OP_TEST    = 30'd130;
  localparam logic [BodyW-1:0] OP_HANDLED = 30'd131;
  localparam logic [BodyW-1:0] OP_HANDLE  = 30'd132;
  localparam logic [BodyW-1:0] OP_HANDLER = 30'd133;
  localparam logic [BodyW-1:0] OP_BIAS    = 30'd134;
  localparam logic [BodyW-1:0] OP_ERR     = 30'd135;
  localparam logic [BodyW-1:0] OP_STAY    = 30'd255;
  localparam logic [BodyW-1:0] OP_FETCH   = 30'd256;
  localparam logic [BodyW-1:0] OP_WRITE   = 30'd257;

  // memory address sources
  typedef enum logic [3:0] {
    A_IN, A_PC, A_SP, A_SP1, A_ACC, A_BACC, A_NIDX, A_T1, A_ERR
  } asel_e;

  // memory write data sources
  typedef enum logic [2:0] {
    W_IN, W_T, W_ACC, W_ZERO, W_SAVE
  } wsel_e;

  // register operations of the datapath
  typedef enum logic [4:0] {
    RO_NONE, RO_LATCH, RO_START, RO_PC_INC, RO_INS, RO_HDR, RO_T, RO_N, RO_RD,
    RO_TOP, RO_ALU, RO_MUL, RO_DIV_GO, RO_DIV_END, RO_R131, RO_NBIAS, RO_ENTER,
    RO_ACC_RD, RO_OUT
  } rop_e;

  typedef struct packed {
    logic            mem_go;
    logic            mem_we;
    asel_e           asel;
    wsel_e           wsel;
    rop_e            rop;
    logic [IdxW-1:0] idx;
  } smc_cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic [1:0]       in_cmd;
    logic             halt;
    logic             err_nz;
    logic [1:0]       hdr;
    logic [BodyW-1:0] op;
    logic             t_zero;
    logic             n_zero;
    logic             rd_zero;
    logic             div_done;
  } smc_stat_t;

  // primitives that read the top of stack first
  function automatic logic op_needs_top(input logic [BodyW-1:0] op);
    logic r;
    r = 1'b0;
    if (op == OP_DUPL || op == OP_TEST || op == OP_HANDLER || op == OP_WRITE) r = 1'b1;
    if (op >= OP_POP && op <= OP_GT && op != OP_NOT) r = 1'b1;
    return r;
  endfunction

endpackage

[rtl/smc_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no dependencies
module smc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/smc_dp.sv]
// datapath: machine registers, alu, multiplier, divider, address reduction, word memory
// depends on smc_pkg and smc_ram
module smc_dp import smc_pkg::*; #(
  parameter int unsigned MemWords = MemWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smc_cmd_t            cmd_i,
  output smc_stat_t           stat_o,
  input  logic [1:0]          in_cmd_i,
  input  logic [AddrInW-1:0]  in_addr_i,
  input  logic [WordW-1:0]    in_data_i,
  input  logic [AddrInW-1:0]  boot_bias_i,
  output logic                halted_o,
  output logic [ErrW-1:0]     err_code_o,
  output logic [WordW-1:0]    acc_value_o,
  output logic [WordW-1:0]    pc_value_o,
  output logic [WordW-1:0]    sp_value_o,
  output logic [WordW-1:0]    bias_value_o,
  output logic [WordW-1:0]    top_value_o,
  output logic                trace_hit_o,
  output logic [WordW-1:0]    read_word_o
);

  localparam int unsigned Aw = $clog2(MemWords);
  localparam logic [32:0] Recip = 33'((64'd1 << 32) / MemWords);
  localparam logic [WordW-1:0] MemW = WordW'(MemWords);

  // architectural registers
  logic [WordW-1:0] acc_q, acc_d, pc_q, pc_d, sp_q, sp_d, bias_q, bias_d, temp_q, temp_d;
  logic             halt_q, halt_d;
  logic [ErrW-1:0]  err_q, err_d;
  // working registers
  logic [1:0]         icmd_q, icmd_d;
  logic [AddrInW-1:0] iaddr_q, iaddr_d;
  logic [WordW-1:0]   idata_q, idata_d;
  logic [WordW-1:0]   ins_q, ins_d, t_q, t_d, n_q, n_d, top_q, top_d, rd_q, rd_d;
  logic               trace_q, trace_d;
  logic [WordW-1:0]   prod_q;
  // divider
  logic [WordW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [5:0]       dcnt_q, dcnt_d;
  logic             dbusy_q, dbusy_d;
  // address pipeline
  logic [WordW-1:0] a1_q, q1_q, wd1_q, wd2_q;
  logic             we1_q, we2_q;
  logic [Aw-1:0]    addr2_q;
  // clearing pass
  logic [Aw-1:0]    clr_q;
  logic             clr_done_q;

  logic [WordW-1:0] raw_addr, wdata, rdata, r2, r2c;
  logic [64:0]      est;
  logic [32:0]      dsh, ddif;
  logic [1:0]       hdr;
  logic [BodyW-1:0] op;

  assign hdr = ins_q[31:30];
  assign op  = ins_q[BodyW-1:0];

  always_comb begin
    unique case (cmd_i.asel)
      A_IN:    raw_addr = {{(WordW-AddrInW){1'b0}}, iaddr_q};
      A_PC:    raw_addr = bias_q + pc_q;
      A_SP:    raw_addr = bias_q + sp_q;
      A_SP1:   raw_addr = bias_q + sp_q + 32'd1;
      A_ACC:   raw_addr = acc_q;
      A_BACC:  raw_addr = bias_q + acc_q;
      A_NIDX:  raw_addr = n_q + {{(WordW-IdxW){1'b0}}, cmd_i.idx};
      A_T1:    raw_addr = t_q + 32'd1;
      A_ERR:   raw_addr = {{(WordW-ErrW){1'b0}}, err_q};
      default: raw_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wsel)
      W_IN:   wdata = idata_q;
      W_T:    wdata = t_q;
      W_ACC:  wdata = acc_q;
      W_ZERO: wdata = '0;
      W_SAVE: begin
        unique case (cmd_i.idx)
          3'd1:    wdata = 32'd1;
          3'd2:    wdata = bias_q;
          3'd3:    wdata = pc_q;
          3'd4:    wdata = sp_q;
          3'd5:    wdata = acc_q;
          3'd6:    wdata = temp_q;
          default: wdata = '0;
        endcase
      end
      default: wdata = '0;
    endcase
  end

  // address modulo the memory size: quotient estimate, then one correction
  assign est = 65'(raw_addr) * 65'(Recip);
  assign r2  = a1_q - WordW'(q1_q * MemW);
  assign r2c = (r2 >= MemW) ? r2 - MemW : r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      we1_q <= 1'b0;
      we2_q <= 1'b0;
    end else begin
      we1_q <= cmd_i.mem_go & cmd_i.mem_we;
      we2_q <= we1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_go) begin
      a1_q  <= raw_addr;
      q1_q  <= est[63:32];
      wd1_q <= wdata;
    end
    addr2_q <= r2c[Aw-1:0];
    wd2_q   <= wd1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_q == Aw'(MemWords - 1)) clr_done_q <= 1'b1;
      else clr_q <= clr_q + 1'b1;
    end
  end

  smc_ram #(.Width(WordW), .Depth(MemWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (!clr_done_q || we2_q),
    .waddr_i (clr_done_q ? addr2_q : clr_q),
    .wdata_i (clr_done_q ? wd2_q : '0),
    .raddr_i (addr2_q),
    .rdata_o (rdata)
  );

  // restoring divider step
  assign dsh  = {rem_q, quo_q[31]};
  assign ddif = dsh - {1'b0, t_q};

  always_comb begin
    acc_d = acc_q; pc_d = pc_q; sp_d = sp_q; bias_d = bias_q; temp_d = temp_q;
    halt_d = halt_q; err_d = err_q;
    icmd_d = icmd_q; iaddr_d = iaddr_q; idata_d = idata_q;
    ins_d = ins_q; t_d = t_q; n_d = n_q; top_d = top_q; rd_d = rd_q; trace_d = trace_q;
    rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q; dbusy_d = dbusy_q;

    if (dbusy_q && dcnt_q != 6'd0) begin
      dcnt_d = dcnt_q - 6'd1;
      if (!ddif[32]) begin
        rem_d = ddif[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = dsh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
    end

    unique case (cmd_i.rop)
      RO_NONE: ;
      RO_LATCH: begin
        icmd_d = in_cmd_i; iaddr_d = in_addr_i; idata_d = in_data_i;
        rd_d = '0; trace_d = 1'b0;
      end
      RO_START: begin
        halt_d = 1'b0; pc_d = '1;
        bias_d = {{(WordW-AddrInW){1'b0}}, boot_bias_i};
      end
      RO_PC_INC: pc_d = pc_q + 32'd1;
      RO_INS:    ins_d = rdata;
      RO_HDR: begin
        if (hdr == HDR_SKIP) pc_d = pc_q + {2'b00, op} - 32'd1;
        else acc_d = ins_q;
      end
      RO_T:      t_d = rdata;
      RO_N:      n_d = rdata;
      RO_RD:     rd_d = rdata;
      RO_TOP:    top_d = rdata;
      RO_ACC_RD: acc_d = rdata;
      RO_MUL: begin
        acc_d = prod_q; sp_d = sp_q - 32'd1;
      end
      RO_DIV_GO: begin
        rem_d = '0; quo_d = acc_q; dcnt_d = 6'd32; dbusy_d = 1'b1;
      end
      RO_DIV_END: begin
        dbusy_d = 1'b0; sp_d = sp_q - 32'd1;
        acc_d = (op == OP_DIV) ? quo_q : rem_q;
      end
      RO_NBIAS: n_d = bias_q;
      RO_R131: begin
        unique case (cmd_i.idx)
          3'd6:    temp_d = rdata;
          3'd5:    acc_d = rdata;
          3'd4:    sp_d = rdata;
          3'd3:    pc_d = rdata;
          3'd2:    bias_d = rdata;
          default: ;
        endcase
      end
      RO_ENTER: begin
        bias_d = n_q; pc_d = '1; sp_d = 32'd6;
      end
      RO_OUT: ;
      RO_ALU: begin
        priority case (op)
          OP_HALT:    halt_d = 1'b1;
          OP_DUPL:    sp_d = sp_q + 32'd1;
          OP_T2A:     acc_d = temp_q;
          OP_A2T:     temp_d = acc_q;
          OP_PUSH:    sp_d = sp_q + 32'd1;
          OP_POP:     begin acc_d = t_q; sp_d = sp_q - 32'd1; end
          OP_ADD:     begin acc_d = acc_q + t_q; sp_d = sp_q - 32'd1; end
          OP_SUB:     begin acc_d = acc_q - t_q; sp_d = sp_q - 32'd1; end
          OP_DIV, OP_MOD: err_d = ERR_DIV0;
          OP_AND:     begin acc_d = acc_q & t_q; sp_d = sp_q - 32'd1; end
          OP_OR:      begin acc_d = acc_q | t_q; sp_d = sp_q - 32'd1; end
          OP_XOR:     begin acc_d = acc_q ^ t_q; sp_d = sp_q - 32'd1; end
          OP_NOT:     acc_d = ~acc_q;
          OP_SHL: begin
            acc_d = (t_q >= 32'd32) ? '0 : acc_q << t_q[4:0];
            sp_d = sp_q - 32'd1;
          end
          OP_SHR: begin
            acc_d = (t_q >= 32'd32) ? '0 : acc_q >> t_q[4:0];
            sp_d = sp_q - 32'd1;
          end
          OP_EQ: begin acc_d = {31'd0, acc_q == t_q}; sp_d = sp_q - 32'd1; end
          OP_LT: begin acc_d = {31'd0, acc_q < t_q}; sp_d = sp_q - 32'd1; end
          OP_GT: begin acc_d = {31'd0, acc_q > t_q}; sp_d = sp_q - 32'd1; end
          OP_TRACE:   trace_d = 1'b1;
          OP_GOTO:    pc_d = acc_q - 32'd1;
          OP_TEST: begin
            sp_d = sp_q - 32'd1;
            if (t_q == '0) pc_d = acc_q - 32'd1;
          end
          OP_HANDLER: sp_d = sp_q - 32'd1;
          OP_BIAS:    bias_d = acc_q;
          OP_ERR:     begin acc_d = {{(WordW-ErrW){1'b0}}, err_q}; err_d = '0; end
          OP_WRITE:   sp_d = sp_q - 32'd1;
          OP_STAY, OP_MUL, OP_HANDLED, OP_HANDLE, OP_FETCH: ;
          default:    err_d = ERR_UNDEF;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; pc_q <= '1; sp_q <= '0; bias_q <= '0; temp_q <= '0;
      halt_q <= 1'b1; err_q <= '0; dbusy_q <= 1'b0;
    end else begin
      acc_q <= acc_d; pc_q <= pc_d; sp_q <= sp_d; bias_q <= bias_d; temp_q <= temp_d;
      halt_q <= halt_d; err_q <= err_d; dbusy_q <= dbusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    icmd_q <= icmd_d; iaddr_q <= iaddr_d; idata_q <= idata_d;
    ins_q <= ins_d; t_q <= t_d; n_q <= n_d; top_q <= top_d; rd_q <= rd_d;
    trace_q <= trace_d;
    rem_q <= rem_d; quo_q <= quo_d; dcnt_q <= dcnt_d;
    prod_q <= WordW'(acc_q * t_q);
    if (cmd_i.rop == RO_OUT) begin
      halted_o     <= halt_q;
      err_code_o   <= err_q;
      acc_value_o  <= acc_q;
      pc_value_o   <= pc_q;
      sp_value_o   <= sp_q;
      bias_value_o <= bias_q;
      top_value_o  <= top_q;
      trace_hit_o  <= trace_q;
      read_word_o  <= rd_q;
    end
  end

  always_comb begin
    stat_o.clr_done = clr_done_q;
    stat_o.in_cmd   = icmd_q;
    stat_o.halt     = halt_q;
    stat_o.err_nz   = (err_q != '0);
    stat_o.hdr      = hdr;
    stat_o.op       = op;
    stat_o.t_zero   = (t_q == '0);
    stat_o.n_zero   = (n_q == '0);
    stat_o.rd_zero  = (rdata == '0);
    stat_o.div_done = dbusy_q && (dcnt_q == 6'd0);
  end

endmodule

[rtl/smc_ctrl.sv]
// controller: sequences each request through memory accesses and datapath operations
// depends on smc_pkg
module smc_ctrl import smc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  smc_stat_t stat_i,
  output smc_cmd_t  cmd_o
);

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE  = 5'd1,  S_DISP  = 5'd2,  S_MWAIT = 5'd3;
  localparam logic [4:0] S_RDCAP = 5'd4,  S_FETCH = 5'd5,  S_DEC   = 5'd6,  S_EXEC  = 5'd7;
  localparam logic [4:0] S_TCAP  = 5'd8,  S_OPT   = 5'd9,  S_W133  = 5'd10, S_MUL   = 5'd11;
  localparam logic [4:0] S_MUL2  = 5'd12, S_DIVW  = 5'd13, S_ACCRD = 5'd14, S_H131  = 5'd15;
  localparam logic [4:0] S_H131C = 5'd16, S_H131Z = 5'd17, S_CHK   = 5'd18, S_NCAP  = 5'd19;
  localparam logic [4:0] S_ENT0  = 5'd20, S_ENT1  = 5'd21, S_ENTW  = 5'd22, S_ENTN  = 5'd23;
  localparam logic [4:0] S_TOPRD = 5'd24, S_TOPC  = 5'd25, S_OUT   = 5'd26;

  logic [4:0]      state_q, state_d, ret_q, ret_d, after_ent;
  logic            wcnt_q, wcnt_d, from_chk_q, from_chk_d, ov_q, ov_d;
  logic [IdxW-1:0] idx_q, idx_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign after_ent   = from_chk_q ? S_TOPRD : S_CHK;

  always_comb begin
    state_d = state_q; ret_d = ret_q; wcnt_d = wcnt_q;
    from_chk_d = from_chk_q; idx_d = idx_q;
    ov_d = ov_q & ~out_ready_i;
    cmd_o = '{mem_go: 1'b0, mem_we: 1'b0, asel: A_IN, wsel: W_ZERO, rop: RO_NONE, idx: idx_q};

    unique case (state_q)
      S_CLEAR: if (stat_i.clr_done) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.rop = RO_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.in_cmd)
          CMD_LOAD: begin
            cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_IN; cmd_o.wsel = W_IN;
            ret_d = S_TOPRD; state_d = S_MWAIT;
          end
          CMD_START: begin
            cmd_o.rop = RO_START; state_d = S_TOPRD;
          end
          CMD_READ: begin
            cmd_o.mem_go = 1'b1; cmd_o.asel = A_IN;
            ret_d = S_RDCAP; state_d = S_MWAIT;
          end
          default: begin
            if (stat_i.halt) state_d = S_TOPRD;
            else begin
              cmd_o.rop = RO_PC_INC; state_d = S_FETCH;
            end
          end
        endcase
        wcnt_d = 1'b0;
      end
      // memory pipeline latency before the read word shows up
      S_MWAIT: begin
        wcnt_d = 1'b1;
        if (wcnt_q) state_d = ret_q;
      end
      S_RDCAP: begin
        cmd_o.rop = RO_RD; state_d = S_TOPRD;
      end
      S_FETCH: begin
        cmd_o.mem_go = 1'b1; cmd_o.asel = A_PC;
        ret_d = S_DEC; wcnt_d = 1'b0; state_d = S_MWAIT;
      end
      S_DEC: begin
        cmd_o.rop = RO_INS; state_d = S_EXEC;
      end
      S_EXEC: begin
        wcnt_d = 1'b0;
        if (stat_i.hdr != HDR_PRIM) begin
          cmd_o.rop = RO_HDR; state_d = S_CHK;
        end else if (op_needs_top(stat_i.op)) begin
          cmd_o.mem_go = 1'b1; cmd_o.asel = A_SP;
          ret_d = S_TCAP; state_d = S_MWAIT;
        end else if (stat_i.op == OP_PUSH) begin
          cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_SP1; cmd_o.wsel = W_ACC;
          cmd_o.rop = RO_ALU; ret_d = S_CHK; state_d = S_MWAIT;
        end else if (stat_i.op == OP_FETCH) begin
          cmd_o.mem_go = 1'b1; cmd_o.asel = A_BACC;
          ret_d = S_ACCRD; state_d = S_MWAIT;
        end else if (stat_i.op == OP_HANDLED) begin
          cmd_o.rop = RO_NBIAS; idx_d = 3'd6; state_d = S_H131;
        end else if (stat_i.op == OP_HANDLE) begin
          cmd_o.mem_go = 1'b1; cmd_o.asel = A_ACC;
          from_chk_d = 1'b0; ret_d = S_NCAP; state_d = S_MWAIT;
        end else begin
          cmd_o.rop = RO_ALU; state_d = S_CHK;
        end
      end
      S_TCAP: begin
        cmd_o.rop = RO_T; state_d = S_OPT;
      end
      S_OPT: begin
        wcnt_d = 1'b0;
        if (stat_i.op == OP_DUPL) begin
          cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_SP1; cmd_o.wsel = W_T;
          cmd_o.rop = RO_ALU; ret_d = S_CHK; state_d = S_MWAIT;
        end else if (stat_i.op == OP_MUL) begin
          state_d = S_MUL;
        end else if ((stat_i.op == OP_DIV || stat_i.op == OP_MOD) && !stat_i.t_zero) begin
          cmd_o.rop = RO_DIV_GO; state_d = S_DIVW;
        end else if (stat_i.op == OP_HANDLER) begin
          cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_ACC; cmd_o.wsel = W_T;
          cmd_o.rop = RO_ALU; ret_d = S_W133; state_d = S_MWAIT;
        end else if (stat_i.op == OP_WRITE) begin
          cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_BACC; cmd_o.wsel = W_T;
          cmd_o.rop = RO_ALU; ret_d = S_CHK; state_d = S_MWAIT;
        end else begin
          cmd_o.rop = RO_ALU; state_d = S_CHK;
        end
      end
      S_W133: begin
        cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_T1; cmd_o.wsel = W_ZERO;
        wcnt_d = 1'b0; ret_d = S_CHK; state_d = S_MWAIT;
      end
      S_MUL:  state_d = S_MUL2;
      S_MUL2: begin
        cmd_o.rop = RO_MUL; state_d = S_CHK;
      end
      S_DIVW: begin
        if (stat_i.div_done) begin
          cmd_o.rop = RO_DIV_END; state_d = S_CHK;
        end
      end
      S_ACCRD: begin
        cmd_o.rop = RO_ACC_RD; state_d = S_CHK;
      end
      // restore the saved registers from the handler frame, top slot first, then clear the enable word
      S_H131: begin
        cmd_o.mem_go = 1'b1; cmd_o.asel = A_NIDX;
        wcnt_d = 1'b0; ret_d = S_H131C; state_d = S_MWAIT;
      end
      S_H131C: begin
        cmd_o.rop = RO_R131;
        if (idx_q == 3'd2) begin
          idx_d = 3'd1; state_d = S_H131Z;
        end else begin
          idx_d = idx_q - 3'd1; state_d = S_H131;
        end
      end
      S_H131Z: begin
        cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_NIDX; cmd_o.wsel = W_ZERO;
        wcnt_d = 1'b0; ret_d = S_CHK; state_d = S_MWAIT;
      end
      S_CHK: begin
        wcnt_d = 1'b0;
        if (stat_i.err_nz) begin
          cmd_o.mem_go = 1'b1; cmd_o.asel = A_ERR;
          from_chk_d = 1'b1; ret_d = S_NCAP; state_d = S_MWAIT;
        end else begin
          state_d = S_TOPRD;
        end
      end
      S_NCAP: begin
        cmd_o.rop = RO_N; idx_d = 3'd1; state_d = S_ENT0;
      end
      S_ENT0: begin
        wcnt_d = 1'b0;
        if (stat_i.n_zero) state_d = after_ent;
        else begin
          cmd_o.mem_go = 1'b1; cmd_o.asel = A_NIDX;
          ret_d = S_ENT1; state_d = S_MWAIT;
        end
      end
      // enable word must be clear to enter
      S_ENT1: state_d = stat_i.rd_zero ? S_ENTW : after_ent;
      S_ENTW: begin
        cmd_o.mem_go = 1'b1; cmd_o.mem_we = 1'b1; cmd_o.asel = A_NIDX; cmd_o.wsel = W_SAVE;
        wcnt_d = 1'b0; ret_d = S_ENTN; state_d = S_MWAIT;
      end
      S_ENTN: begin
        if (idx_q == 3'd6) begin
          cmd_o.rop = RO_ENTER; state_d = after_ent;
        end else begin
          idx_d = idx_q + 3'd1; state_d = S_ENTW;
        end
      end
      S_TOPRD: begin
        cmd_o.mem_go = 1'b1; cmd_o.asel = A_SP;
        wcnt_d = 1'b0; ret_d = S_TOPC; state_d = S_MWAIT;
      end
      S_TOPC: begin
        cmd_o.rop = RO_TOP; state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.rop = RO_OUT; ov_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; ret_q <= S_IDLE; wcnt_q <= 1'b0;
      from_chk_q <= 1'b0; idx_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; wcnt_q <= wcnt_d;
      from_chk_q <= from_chk_d; idx_q <= idx_d; ov_q <= ov_d;
    end
  end

endmodule

[rtl/stack_machine_core.sv]
// top level of the stack machine core: stream ports, boot bias register
// depends on smc_pkg, smc_ctrl, smc_dp (and smc_ram below it)
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid/s_axis_tready    request word, cmd in tuser
//  m_axis    out        m_axis_tvalid/m_axis_tready    result word
//  cfg       in         cfg_valid_i/cfg_ready_o        boot bias
//
// after reset a clearing pass writes zero to every memory word, with s_axis_tready
// low; a memory access runs as issue, pipeline waits and capture; a handle primitive
// can enter a handler twice; a full output register stalls the finished word, and
// a result waits in the output register while the next word is taken in
module stack_machine_core import smc_pkg::*; #(
  parameter int unsigned MemWords = MemWordsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [11:0] addr, [43:12] data, rest zero
  input  logic [47:0]          s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] halted, [7:1] err_code, [39:8] acc_value, [71:40] pc_value,
  // [103:72] sp_value, [135:104] bias_value, [167:136] top_value,
  // [168] trace_hit, [200:169] read_word, rest zero
  output logic [207:0]         m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [AddrInW-1:0]   cfg_data_i
);

  smc_cmd_t          cmd;
  smc_stat_t         stat;
  logic [AddrInW-1:0] boot_bias_q;
  logic              halted, trace_hit;
  logic [ErrW-1:0]   err_code;
  logic [WordW-1:0]  acc_v, pc_v, sp_v, bias_v, top_v, rd_v;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) boot_bias_q <= '0;
    else if (cfg_valid_i) boot_bias_q <= cfg_data_i;
  end

  smc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  smc_dp #(.MemWords(MemWords)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_cmd_i     (s_axis_tuser),
    .in_addr_i    (s_axis_tdata[11:0]),
    .in_data_i    (s_axis_tdata[43:12]),
    .boot_bias_i  (boot_bias_q),
    .halted_o     (halted),
    .err_code_o   (err_code),
    .acc_value_o  (acc_v),
    .pc_value_o   (pc_v),
    .sp_value_o   (sp_v),
    .bias_value_o (bias_v),
    .top_value_o  (top_v),
    .trace_hit_o  (trace_hit),
    .read_word_o  (rd_v)
  );

  assign m_axis_tdata = {7'd0, rd_v, trace_hit, top_v, bias_v, sp_v, pc_v, acc_v,
                         err_code, halted};

endmodule
